### rtl/jss_pkg.sv
// Shared constants and types of the Jacobi stencil sweep block.
`default_nettype none

package jss_pkg;

	// Grid value format: signed Q8.24
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = DATA_WIDTH - 8;

	// Register and result field widths
	localparam int SIZE_WIDTH = 9;
	localparam int RHS_WIDTH  = 32;
	localparam int INV_WIDTH  = 25;
	localparam int SUM_WIDTH  = 63;

	// Configuration port
	localparam int CFG_WIDTH       = 32;
	localparam int CFG_INDEX_WIDTH = 2;

	// Default grid capacity and register reset values
	localparam int MAX_GRID_DEF  = 256;
	localparam int GRID_SIZE_RST = 256;
	localparam int INV_HSQ_RST   = 1;

	// Register indexes
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_GRID_SIZE = 2'd0,
		CFG_RHS_VALUE = 2'd1,
		CFG_INV_HSQ   = 2'd2
	} cfg_index_t;

endpackage : jss_pkg

`default_nettype wire

### rtl/jacobi_stencil_sweep.sv
// Jacobi 5-point stencil sweep with a streaming residual sum, top level.
//
// Grid values of one square grid, ghost border included, enter on the input
// channel (in_valid / in_stall / grid_value) in raster order: grid_size+2 rows
// of grid_size+2 values. Each interior point gives one request on the output
// channel (new_value, square_sum, is_last) when its lower neighbor arrives;
// border values only fill the row store and give nothing.
// One value is taken each cycle while in_stall is low: the two row memories
// (one per row parity) are each read once per accepted value, the one of its
// row's parity is written, and a 5-stage arithmetic pipeline follows them.
// The user must write the configuration port (cfg_we / cfg_index / cfg_data)
// only while idle, not enforced by the block; writing grid_size restarts the sweep.
// Reset clears the counters, the pipeline and the registers to their defaults;
// the row memories are not cleared, since every entry is rewritten in a sweep
// before it is read.
// On a receiver stall the output register holds its request and the stages fill;
// in_stall rises once all are full and stage 1 holds an interior point.
`default_nettype none

module jacobi_stencil_sweep #(
	parameter int MAX_GRID = jss_pkg::MAX_GRID_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Configuration port
	input  wire logic                                cfg_we,
	input  wire logic [jss_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [jss_pkg::CFG_WIDTH-1:0]       cfg_data,
	// Input channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [jss_pkg::DATA_WIDTH-1:0] grid_value,
	// Output channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [jss_pkg::DATA_WIDTH-1:0]    new_value,
	output logic [jss_pkg::SUM_WIDTH-1:0]            square_sum,
	output logic                                     is_last
);
	import jss_pkg::*;

	localparam int ROW_LEN = MAX_GRID + 2;
	localparam int CW      = $clog2(MAX_GRID + 2);
	localparam int SW      = DATA_WIDTH + 3;
	localparam int DW      = DATA_WIDTH + 4;
	localparam int PW      = DW + INV_WIDTH + 1;
	localparam logic signed [PW-1:0] ONE_FX = PW'(1) <<< FRAC_BITS;
	localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// Clamp the written grid size to 1..MAX_GRID
	function automatic logic [CW-1:0] eff_size(input logic [SIZE_WIDTH-1:0] gs);
		logic [31:0] g32;
		g32 = 32'(gs);
		if (g32 == 32'd0) begin
			return CW'(1);
		end else if (g32 > 32'(MAX_GRID)) begin
			return CW'(MAX_GRID);
		end else begin
			return CW'(g32);
		end
	endfunction

	// Configuration registers
	logic [CW-1:0]                n_q;
	logic [CW-1:0]                np1_q;
	logic signed [RHS_WIDTH-1:0]  rhs_q;
	logic [INV_WIDTH-1:0]         inv_q;

	// Position of the next input
	logic [CW-1:0] c_q;
	logic [CW-1:0] r_q;

	// Handshake and stage flow
	logic accept;
	logic free_out, free5, free4, free3, free2, free1, leave1, to_s2;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;

	// Decode of the current position
	logic          cur;
	logic          prod_now;
	logic          last_now;
	logic          first_now;
	logic [CW-1:0] ahead;
	logic [CW-1:0] addr0, addr1;

	// Row memories, one per row parity
	logic signed [DATA_WIDTH-1:0] mem0 [ROW_LEN];
	logic signed [DATA_WIDTH-1:0] mem1 [ROW_LEN];

	// Stage 1: memory data and window
	logic signed [DATA_WIDTH-1:0] rd0_s1, rd1_s1, x_s1;
	logic prod_s1, first_s1, last_s1, zero_s1, cur_s1;
	logic signed [DATA_WIDTH-1:0] wl_q, wc_q, col0_q;
	logic signed [DATA_WIDTH-1:0] right_c, up_c;
	logic signed [SW-1:0]         sum_c, quart_c;
	logic signed [DW-1:0]         diff_c;
	logic signed [DATA_WIDTH-1:0] nv_c;

	// Stages 2 to 5
	logic signed [DATA_WIDTH-1:0] nv_s2, nv_s3, nv_s4, nv_s5;
	logic first_s2, first_s3, first_s4, first_s5;
	logic last_s2, last_s3, last_s4, last_s5;
	logic signed [DW-1:0]         d_s2;
	logic signed [PW-1:0]         prod_s3;
	logic signed [DATA_WIDTH-1:0] res_s4;
	logic [SUM_WIDTH-1:0]         sq_s5;
	logic signed [INV_WIDTH:0]    inv_s;
	logic signed [PW-1:0]         prod_c, shifted_c;
	logic signed [DATA_WIDTH-1:0] res_c;
	logic [DATA_WIDTH-1:0]        mag_c;
	logic [2*DATA_WIDTH-1:0]      sq_c;

	// Output registers
	logic signed [DATA_WIDTH-1:0] new_value_q;
	logic [SUM_WIDTH-1:0]         square_sum_q;
	logic                         is_last_q;
	logic [SUM_WIDTH-1:0]         base_c;
	logic [SUM_WIDTH:0]           total_c;

	// Stage flow: a stage takes a request when it is empty or its request moves on
	assign free_out = !out_valid_q || !out_stall;
	assign free5    = !v_s5 || free_out;
	assign free4    = !v_s4 || free5;
	assign free3    = !v_s3 || free4;
	assign free2    = !v_s2 || free3;
	assign leave1   = !prod_s1 || free2;
	assign free1    = !v_s1 || leave1;
	assign to_s2    = v_s1 && prod_s1 && free2;
	assign in_stall = !free1;
	assign accept   = in_valid && free1;

	// Position decode
	assign cur       = r_q[0];
	assign prod_now  = (r_q >= CW'(2)) && (c_q != '0) && (c_q <= n_q);
	assign last_now  = (r_q == np1_q) && (c_q == n_q);
	assign first_now = (r_q == CW'(2)) && (c_q == CW'(1));
	assign ahead     = (c_q == np1_q) ? '0 : c_q + CW'(1);
	assign addr0     = cur ? ahead : c_q;
	assign addr1     = cur ? c_q : ahead;

	// Configuration registers and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= eff_size(SIZE_WIDTH'(GRID_SIZE_RST));
			np1_q <= eff_size(SIZE_WIDTH'(GRID_SIZE_RST)) + CW'(1);
			rhs_q <= '0;
			inv_q <= INV_WIDTH'(INV_HSQ_RST);
			c_q   <= '0;
			r_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_SIZE: begin
					n_q   <= eff_size(cfg_data[SIZE_WIDTH-1:0]);
					np1_q <= eff_size(cfg_data[SIZE_WIDTH-1:0]) + CW'(1);
					c_q   <= '0;
					r_q   <= '0;
				end
				CFG_RHS_VALUE: rhs_q <= signed'(cfg_data[RHS_WIDTH-1:0]);
				CFG_INV_HSQ:   inv_q <= cfg_data[INV_WIDTH-1:0];
				default: ;
			endcase
		end else if (accept) begin
			// Advance along the row, wrap to the next row and the next grid
			if (c_q == np1_q) begin
				c_q <= '0;
				r_q <= (r_q == np1_q) ? '0 : r_q + CW'(1);
			end else begin
				c_q <= c_q + CW'(1);
			end
		end
	end

	// Row memory of even rows: read old data, write the new value
	always_ff @(posedge clk) begin
		if (accept) begin
			rd0_s1 <= mem0[addr0];
			if (!cur) begin
				mem0[c_q] <= grid_value;
			end
		end
	end

	// Row memory of odd rows
	always_ff @(posedge clk) begin
		if (accept) begin
			rd1_s1 <= mem1[addr1];
			if (cur) begin
				mem1[c_q] <= grid_value;
			end
		end
	end

	// Stage valid flags and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (free1) v_s1 <= accept;
			if (free2) v_s2 <= to_s2;
			if (free3) v_s3 <= v_s2;
			if (free4) v_s4 <= v_s3;
			if (free5) v_s5 <= v_s4;
			if (free_out) out_valid_q <= v_s5;
		end
	end

	// Stage 1 tags of the accepted value
	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1     <= grid_value;
			prod_s1  <= prod_now;
			first_s1 <= first_now;
			last_s1  <= last_now;
			zero_s1  <= (c_q == '0);
			cur_s1   <= cur;
		end
	end

	// Window over the row above: load column 0 at row start, shift as requests leave
	always_ff @(posedge clk) begin
		if (accept && c_q == '0) begin
			wl_q   <= col0_q;
			col0_q <= grid_value;
		end else if (v_s1 && leave1 && !zero_s1) begin
			wl_q <= wc_q;
		end
		if (v_s1 && leave1) begin
			wc_q <= right_c;
		end
	end

	// Stage 1: stencil sums
	always_comb begin
		right_c = cur_s1 ? rd0_s1 : rd1_s1;
		up_c    = cur_s1 ? rd1_s1 : rd0_s1;
		sum_c   = SW'(rhs_q) + SW'(wl_q) + SW'(right_c) + SW'(up_c) + SW'(x_s1);
		quart_c = sum_c >>> 2;
		diff_c  = (DW'(wc_q) <<< 2) - DW'(wl_q) - DW'(right_c) - DW'(up_c) - DW'(x_s1);
		if ((&quart_c[SW-1:DATA_WIDTH-1]) || !(|quart_c[SW-1:DATA_WIDTH-1])) begin
			nv_c = quart_c[DATA_WIDTH-1:0];
		end else begin
			nv_c = quart_c[SW-1] ? DATA_MIN : DATA_MAX;
		end
	end

	// Stage 2: scale by inv_hsq; stage 3: subtract one and saturate; stage 4: square
	always_comb begin
		inv_s     = signed'({1'b0, inv_q});
		prod_c    = d_s2 * inv_s;
		shifted_c = prod_s3 - ONE_FX;
		if ((&shifted_c[PW-1:DATA_WIDTH-1]) || !(|shifted_c[PW-1:DATA_WIDTH-1])) begin
			res_c = shifted_c[DATA_WIDTH-1:0];
		end else begin
			res_c = shifted_c[PW-1] ? DATA_MIN : DATA_MAX;
		end
		mag_c = res_s4[DATA_WIDTH-1] ? (~res_s4 + DATA_WIDTH'(1)) : res_s4;
		sq_c  = mag_c * mag_c;
	end

	// Pipeline registers of stages 2 to 5
	always_ff @(posedge clk) begin
		if (free2) begin
			nv_s2    <= nv_c;
			d_s2     <= diff_c;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
		end
		if (free3) begin
			nv_s3    <= nv_s2;
			prod_s3  <= prod_c;
			first_s3 <= first_s2;
			last_s3  <= last_s2;
		end
		if (free4) begin
			nv_s4    <= nv_s3;
			res_s4   <= res_c;
			first_s4 <= first_s3;
			last_s4  <= last_s3;
		end
		if (free5) begin
			nv_s5    <= nv_s4;
			sq_s5    <= sq_c[SUM_WIDTH-1:0];
			first_s5 <= first_s4;
			last_s5  <= last_s4;
		end
	end

	// Accumulate squares, restart on the first interior point of a sweep
	always_comb begin
		base_c  = first_s5 ? '0 : square_sum_q;
		total_c = {1'b0, base_c} + {1'b0, sq_s5};
	end

	// Output register
	always_ff @(posedge clk) begin
		if (v_s5 && free_out) begin
			new_value_q  <= nv_s5;
			is_last_q    <= last_s5;
			square_sum_q <= total_c[SUM_WIDTH] ? '1 : total_c[SUM_WIDTH-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign new_value  = new_value_q;
	assign square_sum = square_sum_q;
	assign is_last    = is_last_q;

endmodule : jacobi_stencil_sweep

`default_nettype wire
